// File: rtl/kab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kab_pkg
// Shared types, constants and helpers of the angle/bias Kalman filter.
// ----------------------------------------------------------------------------
package kab_pkg;

    localparam int ANGLE_W  = 25;
    localparam int DT_W     = 16;
    localparam int NOISE_W  = 31;
    localparam int EST_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int MUL_A_W  = 35;
    localparam int MUL_B_W  = 33;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int GAIN_FRAC = 30;
    localparam int DIV_NUM_W = EST_W + GAIN_FRAC;
    localparam int DIV_DEN_W = EST_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE  = 2'd2;

    localparam logic [NOISE_W-1:0] ANGLE_NOISE_RST = 31'd16777;
    localparam logic [NOISE_W-1:0] BIAS_NOISE_RST  = 31'd50332;
    localparam logic [NOISE_W-1:0] MEAS_NOISE_RST  = 31'd503316;

    typedef enum logic [4:0] {
        S_IDLE, S_RATE, S_DP, S_T, S_TM, S_QB, S_P11, S_S, S_D0, S_D1,
        S_Y, S_K0Y, S_K1Y, S_C11, S_C01, S_C10, S_C00, S_P00, S_FIN
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [EST_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi)
            return 32'sh7FFF_FFFF;
        else if (v < lo)
            return 32'sh8000_0000;
        else
            return EST_W'(v);
    endfunction

endpackage

// File: rtl/kab_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kab_if
// Valid/ready channels of the filter: sample in, result out, register write.
// ----------------------------------------------------------------------------
interface kab_in_if;
    logic                     valid;
    logic                     ready;
    logic signed [24:0]       measured_angle;
    logic signed [24:0]       gyro_rate;
    logic        [15:0]       time_step;
    modport source (output valid, measured_angle, gyro_rate, time_step, input ready);
    modport sink   (input valid, measured_angle, gyro_rate, time_step, output ready);
endinterface

interface kab_out_if;
    logic                     valid;
    logic                     ready;
    logic signed [31:0]       filtered_angle;
    logic signed [31:0]       rate_bias;
    modport source (output valid, filtered_angle, rate_bias, input ready);
    modport sink   (input valid, filtered_angle, rate_bias, output ready);
endinterface

interface kab_cfg_if;
    logic                     valid;
    logic                     ready;
    logic        [1:0]        index;
    logic        [30:0]       data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/kab_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kab_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module kab_mul
    import kab_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [PROD_W-1:0]  prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

// File: rtl/kab_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kab_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kab_div
    import kab_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIV_NUM_W-1:0]  num,
    input  logic [DIV_DEN_W-1:0]  den,
    output logic [DIV_NUM_W-1:0]  quo,
    output div_stat_t             stat
);

    localparam int CNT_W = $clog2(DIV_NUM_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_NUM_W - 1);

    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   trial;
    logic                 ge;

    // Shift in the next dividend bit and try the subtract.
    assign trial = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? DIV_DEN_W'(trial - {1'b0, den_reg}) : DIV_DEN_W'(trial);
            num_reg <= {num_reg[DIV_NUM_W-2:0], ge};
        end
    end

    assign quo       = num_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: rtl/kalman_angle_bias_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter
// Two-state Kalman filter fusing a measured angle with a gyro rate.
// ----------------------------------------------------------------------------
// One sample word in, one result word out. Each sample runs the predict step,
// the gain and the correction on one shared 35x33 multiplier and one
// bit-serial divider under a small sequencer; the block takes no new sample
// until the current one has reached the output register. Each of the two gain
// quotients is 62 bits wide, built one quotient bit per cycle in the divider;
// the other 16 steps are multiplier and bookkeeping steps. When the innovation
// variance is zero the divider is skipped. The block is ready for the next
// sample once the result is loaded; a stalled output register holds the
// sequencer in its last step. Registers are written through the cfg channel,
// which is always ready; write them only while no sample is in flight. Writes
// to an unused index are dropped.
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter
    import kab_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    kab_in_if.sink     sample,
    kab_out_if.source  result,
    kab_cfg_if.sink    cfg
);

    state_t state_reg, state_next;

    // configuration
    logic [NOISE_W-1:0] qa_reg, qb_reg, r_reg;

    // sample hold
    logic signed [ANGLE_W-1:0] meas_reg, gyro_reg;
    logic        [DT_W-1:0]    dt_reg;

    // filter state and working values
    logic signed [EST_W-1:0] angle_reg, bias_reg;
    logic signed [EST_W-1:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [EST_W:0]   dp_reg, s_reg;
    logic signed [EST_W-1:0] k0_reg, k1_reg, y_reg;
    logic                    qneg_reg;

    // output register
    logic                    out_valid_reg;
    logic signed [EST_W-1:0] out_angle_reg, out_bias_reg;

    // shared units
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [63:0]        sh16, sh30;

    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_NUM_W-1:0] div_quo;
    div_stat_t            div_stat;
    logic signed [63:0]   quo_s;
    logic                 div_neg;

    logic signed [MUL_B_W-1:0] dt_s;
    logic signed [EST_W:0]     s_val;
    logic                      out_free;
    logic                      in_take;

    assign dt_s     = $signed({{(MUL_B_W-DT_W){1'b0}}, dt_reg});
    assign sh16     = 64'(prod >>> 16);
    assign sh30     = 64'(prod >>> GAIN_FRAC);
    assign s_val    = (EST_W+1)'(p00_reg) + $signed({2'b00, r_reg});
    assign out_free = !out_valid_reg || result.ready;
    assign in_take  = sample.valid && sample.ready;
    assign quo_s    = qneg_reg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});

    kab_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    kab_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .stat  (div_stat)
    );

    // Next state: walk the fixed step list, wait on the divider and output.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (sample.valid) state_next = S_RATE;
            S_RATE:  state_next = S_DP;
            S_DP:    state_next = S_T;
            S_T:     state_next = S_TM;
            S_TM:    state_next = S_QB;
            S_QB:    state_next = S_P11;
            S_P11:   state_next = S_S;
            S_S:     state_next = (s_reg == '0) ? S_Y : S_D0;
            S_D0:    if (div_stat.done) state_next = S_D1;
            S_D1:    if (div_stat.done) state_next = S_Y;
            S_Y:     state_next = S_K0Y;
            S_K0Y:   state_next = S_K1Y;
            S_K1Y:   state_next = S_C11;
            S_C11:   state_next = S_C01;
            S_C01:   state_next = S_C10;
            S_C10:   state_next = S_C00;
            S_C00:   state_next = S_P00;
            S_P00:   state_next = S_FIN;
            S_FIN:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Unit controls: multiplier operands and divider launches per step.
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_neg   = 1'b0;
        div_num   = '0;
        div_den   = s_reg[EST_W] ? DIV_DEN_W'(-s_reg) : DIV_DEN_W'(s_reg);
        unique case (state_reg)
            S_RATE:
            begin
                mul_a = MUL_A_W'(gyro_reg) - MUL_A_W'(bias_reg);
                mul_b = dt_s;
            end
            S_DP:
            begin
                mul_a = MUL_A_W'(p11_reg);
                mul_b = dt_s;
            end
            S_TM:
            begin
                mul_a = MUL_A_W'(dp_reg) - MUL_A_W'(p01_reg) - MUL_A_W'(p10_reg)
                        + $signed({4'b0000, qa_reg});
                mul_b = dt_s;
            end
            S_QB:
            begin
                mul_a = $signed({4'b0000, qb_reg});
                mul_b = dt_s;
            end
            S_S:
            begin
                div_start = (s_reg != '0);
                div_neg   = p00_reg[EST_W-1] ^ s_reg[EST_W];
                div_num   = {(p00_reg[EST_W-1] ? EST_W'(-(EST_W+1)'(p00_reg))
                                               : EST_W'(p00_reg)), {GAIN_FRAC{1'b0}}};
            end
            S_D0:
            begin
                div_start = div_stat.done;
                div_neg   = p10_reg[EST_W-1] ^ s_reg[EST_W];
                div_num   = {(p10_reg[EST_W-1] ? EST_W'(-(EST_W+1)'(p10_reg))
                                               : EST_W'(p10_reg)), {GAIN_FRAC{1'b0}}};
            end
            S_K0Y:
            begin
                mul_a = MUL_A_W'(k0_reg);
                mul_b = MUL_B_W'(y_reg);
            end
            S_K1Y:
            begin
                mul_a = MUL_A_W'(k1_reg);
                mul_b = MUL_B_W'(y_reg);
            end
            S_C11:
            begin
                mul_a = MUL_A_W'(k1_reg);
                mul_b = MUL_B_W'(p01_reg);
            end
            S_C01:
            begin
                mul_a = MUL_A_W'(k0_reg);
                mul_b = MUL_B_W'(p01_reg);
            end
            S_C10:
            begin
                mul_a = MUL_A_W'(k1_reg);
                mul_b = MUL_B_W'(p00_reg);
            end
            S_C00:
            begin
                mul_a = MUL_A_W'(k0_reg);
                mul_b = MUL_B_W'(p00_reg);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            qa_reg        <= ANGLE_NOISE_RST;
            qb_reg        <= BIAS_NOISE_RST;
            r_reg         <= MEAS_NOISE_RST;
            angle_reg     <= '0;
            bias_reg      <= '0;
            p00_reg       <= '0;
            p01_reg       <= '0;
            p10_reg       <= '0;
            p11_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // Register writes; drop unused indexes.
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_ANGLE_NOISE: qa_reg <= cfg.data;
                    REG_BIAS_NOISE:  qb_reg <= cfg.data;
                    REG_MEAS_NOISE:  r_reg  <= cfg.data;
                    default:         ;
                endcase
            end

            // Load a finished result, or drop the word once it is taken.
            if (state_reg == S_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (result.valid && result.ready)
                out_valid_reg <= 1'b0;

            // Each step folds in the product issued in the step before it, or the held dp_reg.
            unique case (state_reg)
                S_DP:    angle_reg <= sat32(64'(angle_reg) + sh16);
                S_TM:
                begin
                    p01_reg <= sat32(64'(p01_reg) - 64'(dp_reg));
                    p10_reg <= sat32(64'(p10_reg) - 64'(dp_reg));
                end
                S_QB:    p00_reg <= sat32(64'(p00_reg) + sh16);
                S_P11:   p11_reg <= sat32(64'(p11_reg) + sh16);
                S_K1Y:   angle_reg <= sat32(64'(angle_reg) + sh30);
                S_C11:   bias_reg <= sat32(64'(bias_reg) + sh30);
                S_C01:   p11_reg <= sat32(64'(p11_reg) - sh30);
                S_C10:   p01_reg <= sat32(64'(p01_reg) - sh30);
                S_C00:   p10_reg <= sat32(64'(p10_reg) - sh30);
                S_P00:   p00_reg <= sat32(64'(p00_reg) - sh30);
                default: ;
            endcase
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            meas_reg <= sample.measured_angle;
            gyro_reg <= sample.gyro_rate;
            dt_reg   <= sample.time_step;
        end
        if (div_start)
            qneg_reg <= div_neg;
        unique case (state_reg)
            S_T:     dp_reg <= (EST_W+1)'(sh16);
            S_P11:   s_reg  <= s_val;
            S_S:
            begin
                if (s_reg == '0)
                begin
                    k0_reg <= '0;
                    k1_reg <= '0;
                end
            end
            S_D0:    if (div_stat.done) k0_reg <= sat32(quo_s);
            S_D1:    if (div_stat.done) k1_reg <= sat32(quo_s);
            S_Y:     y_reg <= sat32(64'(meas_reg) - 64'(angle_reg));
            S_FIN:
            begin
                if (out_free)
                begin
                    out_angle_reg <= angle_reg;
                    out_bias_reg  <= bias_reg;
                end
            end
            default: ;
        endcase
    end

    assign sample.ready          = (state_reg == S_IDLE);
    assign cfg.ready             = 1'b1;
    assign result.valid          = out_valid_reg;
    assign result.filtered_angle = out_angle_reg;
    assign result.rate_bias      = out_bias_reg;

    // A quotient only comes back while the sequencer waits for one.
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_D0 || state_reg == S_D1))
        else $error("divider finished outside a gain step");

    // An accepted sample starts the predict step next cycle.
    a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == S_RATE))
        else $error("accepted sample did not start the sequence");

    // Finishing with a free output slot presents the result next cycle.
    a_fin_presents: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_free) |=> (result.valid && state_reg == S_IDLE))
        else $error("result not presented after finish");

    // The divider is never relaunched while it is mid-quotient.
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

endmodule
